// ===== hw/rtl/sliding_window_velocity_fit_defines.svh =====
// Assertion macros for the checker file of the velocity fit block.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef SLIDING_WINDOW_VELOCITY_FIT_DEFINES_SVH
`define SLIDING_WINDOW_VELOCITY_FIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWVF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/swvf_pkg.sv =====
// ----------------------------------------------------------------------------
// swvf_pkg
// Widths, window size and field types of the sliding-window velocity fit.
// ----------------------------------------------------------------------------
package swvf_pkg;

  // Window length (2 to 16); sum widths below cover the largest window
  localparam int WINDOW     = 5;
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);

  // Port field widths
  localparam int TS_W       = 40;
  localparam int POS_W      = 32;
  localparam int SCALE_W    = 16;
  localparam int LIMIT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Internal datapath widths
  localparam int T_W        = 24;
  localparam int DIFF_W     = 32;
  localparam int SPROD_W    = DIFF_W + SCALE_W;
  localparam int TSUM_W     = 28;
  localparam int TSQ_W      = 52;
  localparam int PSUM_W     = 36;
  localparam int TPSUM_W    = 60;
  localparam int NST_W      = TSQ_W + 5;
  localparam int MA_W       = 37;
  localparam int MB_W       = 29;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int NUM_W      = 66;
  localparam int FRAC_W     = 16;
  localparam int Q_W        = 2 * FRAC_W;
  localparam int QCNT_W     = $clog2(Q_W);
  localparam int AXES       = 3;
  localparam int AXIS_W     = $clog2(AXES);

  typedef logic [TS_W-1:0]         ts_t;
  typedef logic signed [POS_W-1:0] pos_t;

endpackage

// ===== hw/rtl/sliding_window_velocity_fit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_velocity_fit: least-squares slope over the last WINDOW samples
// A request runs the scale, time and product steps; a full window then forms the
// denominator and, per axis, the numerator and a 1-bit-a-cycle divide of 32 steps,
// three axes (zero time spread skips to done; a saturating axis skips its divide).
// A new request is taken only after the result is loaded into the output register.
// Synchronous active-low reset clears the window, the sums and the result valid.
// ----------------------------------------------------------------------------
module sliding_window_velocity_fit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  swvf_pkg::ts_t                       in_timestamp,
  input  swvf_pkg::pos_t                      in_pos_x,
  input  swvf_pkg::pos_t                      in_pos_y,
  input  swvf_pkg::pos_t                      in_pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_ready_res,
  output swvf_pkg::pos_t                      out_vel_x,
  output swvf_pkg::pos_t                      out_vel_y,
  output swvf_pkg::pos_t                      out_vel_z,
  output logic                                out_approaching,
  output logic                                out_degenerate,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swvf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swvf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import swvf_pkg::*;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_LIMIT = CFG_IDX_W'(1);

  localparam logic [SCALE_W-1:0]        SCALE_RESET = SCALE_W'(256);
  localparam logic signed [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(-6554);
  localparam logic [POS_W-1:0]          VEL_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0]          VEL_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SCALE = 4'd1;
  localparam logic [3:0] ST_TIME  = 4'd2;
  localparam logic [3:0] ST_PMUL  = 4'd3;
  localparam logic [3:0] ST_PACC  = 4'd4;
  localparam logic [3:0] ST_DMUL  = 4'd5;
  localparam logic [3:0] ST_DEN   = 4'd6;
  localparam logic [3:0] ST_NMUL  = 4'd7;
  localparam logic [3:0] ST_NUM   = 4'd8;
  localparam logic [3:0] ST_DIV   = 4'd9;
  localparam logic [3:0] ST_AXIS  = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0]                  state_r, state_nxt;

  // Configuration
  logic [SCALE_W-1:0]          scale_r;
  logic signed [LIMIT_W-1:0]   limit_r;

  // Window state
  ts_t                         origin_r;
  logic [CNT_W-1:0]            fill_r;
  logic [SLOT_W-1:0]           slot_r;
  logic [T_W-1:0]              t_ring_r [WINDOW];
  pos_t                        p_ring_r [WINDOW][AXES];
  logic [TSUM_W-1:0]           tsum_r;
  logic [TSQ_W-1:0]            tsq_r;
  logic signed [PSUM_W-1:0]    psum_r  [AXES];
  logic signed [TPSUM_W-1:0]   tpsum_r [AXES];

  // Per-request working registers
  logic [DIFF_W-1:0]           diff_r;
  logic                        tneg_r, tbig_r;
  pos_t                        pin_r [AXES];
  logic [T_W-1:0]              t_r, ot_r;
  pos_t                        op_r [AXES];
  logic                        res_r, degen_r;
  logic [2:0]                  k_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic [NST_W-1:0]            den_r;
  logic [AXIS_W-1:0]           axis_r;
  logic                        neg_r, big_r;
  logic [NST_W-1:0]            rem_r;
  logic [Q_W-1:0]              lo_r, q_r;
  logic [QCNT_W-1:0]           cnt_r;
  pos_t                        vel_r [AXES];

  // Output register
  logic                        out_valid_r, out_res_r, out_appr_r, out_degen_r;
  pos_t                        out_vx_r, out_vy_r, out_vz_r;

  // Combinational helpers
  logic [TS_W:0]               diff_in;
  logic                        full_w;
  logic [T_W-1:0]              ot_w;
  pos_t                        op_w [AXES];
  logic [T_W-1:0]              t_nxt;
  logic [AXIS_W-1:0]           acc_idx;
  logic [T_W-1:0]              tsel;
  pos_t                        psel;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]    mul_p;
  logic [NST_W-1:0]            nst_w, st2_w, den_nxt;
  logic                        den_zero;
  logic signed [NUM_W-1:0]     num_w;
  logic [NUM_W-1:0]            mag_w;
  logic                        big_w;
  logic [NST_W:0]              r2_w;
  logic                        ge_w;
  logic [NST_W-1:0]            rem_nxt;
  pos_t                        vel_nxt;
  logic                        load_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Take register writes at any time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIME_SCALE:     scale_r <= cfg_data[SCALE_W-1:0];
        CFG_APPROACH_LIMIT: limit_r <= $signed(cfg_data[LIMIT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Relative time against the origin; first sample becomes the origin
  assign diff_in = {1'b0, in_timestamp} - {1'b0, origin_r};

  // Eviction only once the window is full
  assign full_w = (fill_r == CNT_W'(WINDOW));
  assign ot_w   = full_w ? t_ring_r[slot_r] : '0;
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      op_w[a] = full_w ? p_ring_r[slot_r][a] : '0;
    end
  end

  // Scale result to Q8.16 with saturation
  always_comb begin
    if (tneg_r) begin
      t_nxt = '0;
    end else if (tbig_r) begin
      t_nxt = (scale_r != '0) ? '1 : '0;
    end else if (|prod_r[SPROD_W-1:DIFF_W]) begin
      t_nxt = '1;
    end else begin
      t_nxt = prod_r[DIFF_W-1:8];
    end
  end

  // Product step k: k[2] picks new or evicted sample, k[1:0] the term
  assign acc_idx = AXIS_W'(k_r[1:0] - 2'd1);
  assign tsel    = k_r[2] ? t_r : ot_r;
  assign psel    = k_r[2] ? pin_r[acc_idx] : op_r[acc_idx];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SCALE: begin
        mul_a = $signed({{(MA_W-DIFF_W){1'b0}}, diff_r});
        mul_b = $signed({{(MB_W-SCALE_W){1'b0}}, scale_r});
      end
      ST_PMUL: begin
        if (k_r[1:0] == 2'd0) begin
          mul_a = $signed({{(MA_W-T_W){1'b0}}, tsel});
        end else begin
          mul_a = MA_W'(psel);
        end
        mul_b = $signed({{(MB_W-T_W){1'b0}}, tsel});
      end
      ST_DMUL: begin
        mul_a = $signed({{(MA_W-TSUM_W){1'b0}}, tsum_r});
        mul_b = $signed({{(MB_W-TSUM_W){1'b0}}, tsum_r});
      end
      ST_NMUL: begin
        mul_a = MA_W'(psum_r[axis_r]);
        mul_b = $signed({{(MB_W-TSUM_W){1'b0}}, tsum_r});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Denominator N*sum(t^2) - sum(t)^2, clamped at zero
  assign nst_w    = NST_W'(WINDOW) * {{(NST_W-TSQ_W){1'b0}}, tsq_r};
  assign st2_w    = prod_r[NST_W-1:0];
  assign den_nxt  = (nst_w > st2_w) ? (nst_w - st2_w) : '0;
  assign den_zero = !(nst_w > st2_w);

  // Numerator N*sum(t*p) - sum(p)*sum(t), split into sign and magnitude
  assign num_w = $signed(NUM_W'(WINDOW)) * NUM_W'(tpsum_r[axis_r]) - prod_r;
  assign mag_w = num_w[NUM_W-1] ? NUM_W'(-num_w) : NUM_W'(num_w);
  assign big_w = (NST_W'(mag_w[NUM_W-1:FRAC_W]) >= den_r);

  // One restoring divide step
  assign r2_w    = {rem_r, lo_r[Q_W-1]};
  assign ge_w    = (r2_w >= {1'b0, den_r});
  assign rem_nxt = ge_w ? NST_W'(r2_w - {1'b0, den_r}) : NST_W'(r2_w);

  // Saturate quotient to signed Q16.16
  always_comb begin
    if (neg_r) begin
      vel_nxt = (big_r || (q_r > VEL_MIN)) ? $signed(VEL_MIN) : $signed(POS_W'(-q_r));
    end else begin
      vel_nxt = (big_r || q_r[Q_W-1]) ? $signed(VEL_MAX) : $signed(q_r);
    end
  end

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_TIME;
      ST_TIME:  state_nxt = ST_PMUL;
      ST_PMUL:  state_nxt = ST_PACC;
      ST_PACC: begin
        if (k_r == 3'd7) begin
          state_nxt = res_r ? ST_DMUL : ST_DONE;
        end else begin
          state_nxt = ST_PMUL;
        end
      end
      ST_DMUL:  state_nxt = ST_DEN;
      ST_DEN:   state_nxt = den_zero ? ST_DONE : ST_NMUL;
      ST_NMUL:  state_nxt = ST_NUM;
      ST_NUM:   state_nxt = big_w ? ST_AXIS : ST_DIV;
      ST_DIV:   if (cnt_r == QCNT_W'(Q_W - 1)) state_nxt = ST_AXIS;
      ST_AXIS:  state_nxt = (axis_r == AXIS_W'(AXES - 1)) ? ST_DONE : ST_NMUL;
      ST_DONE:  if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state, window counters and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      origin_r    <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      tsum_r      <= '0;
      tsq_r       <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        psum_r[a]  <= '0;
        tpsum_r[a] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Fix the time origin on the first sample
      if (state_r == ST_IDLE && in_valid && fill_r == '0) begin
        origin_r <= in_timestamp;
      end

      // Drop the evicted sample and add the new one to the linear sums
      if (state_r == ST_TIME) begin
        tsum_r <= tsum_r - TSUM_W'(ot_w) + TSUM_W'(t_nxt);
        for (int a = 0; a < AXES; a++) begin
          psum_r[a] <= psum_r[a] - PSUM_W'(op_w[a]) + PSUM_W'(pin_r[a]);
        end
        if (!full_w) begin
          fill_r <= fill_r + CNT_W'(1);
        end
        slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
      end

      // Add (new sample) or subtract (evicted sample) one product in its sum
      if (state_r == ST_PACC) begin
        if (k_r[1:0] == 2'd0) begin
          tsq_r <= k_r[2] ? tsq_r + prod_r[TSQ_W-1:0] : tsq_r - prod_r[TSQ_W-1:0];
        end else if (k_r[2]) begin
          tpsum_r[acc_idx] <= tpsum_r[acc_idx] + $signed(prod_r[TPSUM_W-1:0]);
        end else begin
          tpsum_r[acc_idx] <= tpsum_r[acc_idx] - $signed(prod_r[TPSUM_W-1:0]);
        end
      end

      // Hold the result until taken
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r) inside
      ST_IDLE: begin
        if (in_valid) begin
          if (fill_r == '0) begin
            diff_r <= '0;
            tneg_r <= 1'b0;
            tbig_r <= 1'b0;
          end else begin
            diff_r <= diff_in[DIFF_W-1:0];
            tneg_r <= diff_in[TS_W];
            tbig_r <= |diff_in[TS_W-1:DIFF_W];
          end
          pin_r[0] <= in_pos_x;
          pin_r[1] <= in_pos_y;
          pin_r[2] <= in_pos_z;
          for (int a = 0; a < AXES; a++) begin
            vel_r[a] <= '0;
          end
          degen_r <= 1'b0;
        end
      end
      ST_SCALE, ST_PMUL, ST_DMUL, ST_NMUL: begin
        prod_r <= mul_p;
      end
      ST_TIME: begin
        t_r  <= t_nxt;
        ot_r <= ot_w;
        t_ring_r[slot_r] <= t_nxt;
        for (int a = 0; a < AXES; a++) begin
          op_r[a] <= op_w[a];
          p_ring_r[slot_r][a] <= pin_r[a];
        end
        res_r <= full_w || (fill_r == CNT_W'(WINDOW - 1));
        k_r   <= '0;
      end
      ST_PACC: begin
        k_r <= k_r + 3'd1;
      end
      ST_DEN: begin
        den_r   <= den_nxt;
        degen_r <= den_zero;
        axis_r  <= '0;
      end
      ST_NUM: begin
        neg_r <= num_w[NUM_W-1];
        big_r <= big_w;
        rem_r <= NST_W'(mag_w[NUM_W-1:FRAC_W]);
        lo_r  <= {mag_w[FRAC_W-1:0], {FRAC_W{1'b0}}};
        q_r   <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[Q_W-2:0], ge_w};
        lo_r  <= {lo_r[Q_W-2:0], 1'b0};
        cnt_r <= cnt_r + QCNT_W'(1);
      end
      ST_AXIS: begin
        vel_r[axis_r] <= vel_nxt;
        axis_r <= axis_r + AXIS_W'(1);
      end
      ST_DONE: begin
        if (load_out) begin
          out_res_r   <= res_r;
          out_degen_r <= degen_r;
          out_vx_r    <= vel_r[0];
          out_vy_r    <= vel_r[1];
          out_vz_r    <= vel_r[2];
          out_appr_r  <= res_r && !degen_r && (vel_r[0] <= limit_r);
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_ready_res   = out_res_r;
  assign out_vel_x       = out_vx_r;
  assign out_vel_y       = out_vy_r;
  assign out_vel_z       = out_vz_r;
  assign out_approaching = out_appr_r;
  assign out_degenerate  = out_degen_r;

endmodule

// ===== hw/rtl/swvf_checker.sv =====
// ----------------------------------------------------------------------------
// swvf_checker
// Port-level checks on the velocity fit block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_velocity_fit_defines.svh"

module swvf_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_ready_res,
  input swvf_pkg::pos_t  out_vel_x,
  input swvf_pkg::pos_t  out_vel_y,
  input swvf_pkg::pos_t  out_vel_z,
  input logic            out_approaching,
  input logic            out_degenerate
);

  logic vel_zero;

  assign vel_zero = (out_vel_x == '0) && (out_vel_y == '0) && (out_vel_z == '0);

  // Block goes busy right after taking a request
  `SWVF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // Partial window gives an all-zero result
  `SWVF_ASSERT_NOW(a_fill_zero, out_valid && !out_ready_res, vel_zero && !out_approaching && !out_degenerate, "nonzero result before window full")

  // Zero time spread forces zero velocities
  `SWVF_ASSERT_NOW(a_degen_zero, out_valid && out_degenerate, out_ready_res && vel_zero && !out_approaching, "degenerate result not cleared")

  // Stalled result stays valid and keeps its x velocity and ready flag
  `SWVF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_vel_x) && $stable(out_ready_res), "result changed while stalled")

endmodule

bind sliding_window_velocity_fit swvf_checker u_swvf_checker (.*);
